FILE: hw/rtl/sfs_pkg.sv
// Shared types, widths and codes of the sprite frame sequencer.
// No dependencies; every other file refers to it by scoped names.
package sfs_pkg;

	localparam int unsigned MAX_FRAMES = 256;
	localparam int unsigned FRAME_W    = 8;   // frame index width
	localparam int unsigned COUNT_W    = 9;   // frame count width, holds MAX_FRAMES
	localparam int unsigned ACC_W      = 32;  // time accumulator, 1/256 us units
	localparam int unsigned DUR_W      = 24;
	localparam int unsigned SPEED_W    = 16;
	localparam int unsigned LOOP_W     = 16;
	localparam int unsigned DELTA_W    = 16;
	localparam int unsigned ADDR_W     = 5;
	localparam int unsigned DATA_W     = 32;

	// register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_FRAME_COUNT    = 3'd0;
	localparam logic [2:0] REG_FRAME_DURATION = 3'd1;
	localparam logic [2:0] REG_SPEED          = 3'd2;
	localparam logic [2:0] REG_PLAY_MODE      = 3'd3;
	localparam logic [2:0] REG_LOOP_TOTAL     = 3'd4;
	localparam logic [2:0] REG_EVENT_START    = 3'd5;
	localparam logic [2:0] REG_EVENT_LENGTH   = 3'd6;

	// play modes; the unused code plays once
	localparam logic [1:0] MODE_ONCE    = 2'd0;
	localparam logic [1:0] MODE_LOOP    = 2'd1;
	localparam logic [1:0] MODE_COUNTED = 2'd2;

	// request operations
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef struct packed {
		logic [COUNT_W-1:0] frame_count;
		logic [DUR_W-1:0]   frame_duration;
		logic [SPEED_W-1:0] speed;
		logic [1:0]         play_mode;
		logic [LOOP_W-1:0]  loop_total;
		logic [FRAME_W-1:0] event_start;
		logic [COUNT_W-1:0] event_length;
	} cfg_t;

	typedef struct packed {
		logic             op;
		logic [ACC_W-1:0] scaled;  // delta_time * speed
	} item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_index;
		logic               event_before;
		logic               event_after;
		logic               finished_now;
		logic               finished;
	} res_t;

endpackage

FILE: hw/rtl/sprite_frame_sequencer_unit.sv
// Top level of the sprite frame sequencer: input stage, core, result register.
// Depends on sfs_pkg, sfs_regs and sfs_core.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------
//  input     | in_valid / in_ready     | operation, delta_time
//  result    | out_valid / out_ready   | frame_index, event_before, event_after,
//            |                         | finished_now, finished
//  config    | psel/penable/pwrite     | paddr, pwdata, prdata (pready tied high)
//
// An accepted request enters the stage-1 register, holding the operation and
// delta_time * speed (the one multiplier); the core then updates state and
// loads the result register. One request per cycle while out_ready is high.
// Reset clears all control and sequencer state; no clearing pass is needed.
// A stalled result holds the result register, the stage-1 request waits behind
// it, and in_ready drops only when both are occupied and out_ready is low.
module sprite_frame_sequencer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// input requests
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [sfs_pkg::DELTA_W-1:0]   delta_time,
	// results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sfs_pkg::FRAME_W-1:0]   frame_index,
	output logic                          event_before,
	output logic                          event_after,
	output logic                          finished_now,
	output logic                          finished,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfs_pkg::ADDR_W-1:0]    paddr,
	input  logic [sfs_pkg::DATA_W-1:0]    pwdata,
	output logic [sfs_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	sfs_pkg::cfg_t  cfg;
	sfs_pkg::item_t item_s1;
	sfs_pkg::res_t  res_c, res_q;
	logic           valid_s1;
	logic           out_valid_q;
	logic           advance;   // stage-1 request moves into the result register
	logic           in_acc;

	assign pready = 1'b1;

	sfs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// result slot frees when empty or being taken this cycle
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_acc   = in_valid && in_ready;

	// stage 1: operation and scaled elapsed time (Q.8 microseconds)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.op     <= operation;
			item_s1.scaled <= sfs_pkg::ACC_W'(delta_time) * sfs_pkg::ACC_W'(cfg.speed);
		end
	end

	sfs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_index  = res_q.frame_index;
	assign event_before = res_q.event_before;
	assign event_after  = res_q.event_after;
	assign finished_now = res_q.finished_now;
	assign finished     = res_q.finished;

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(res_q))
		else $error("stalled result was lost or changed");

	a_stage_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stage-1 request lost while blocked");

	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled while a slot was free");

endmodule

FILE: hw/rtl/sfs_regs.sv
// APB-style configuration registers of the sprite frame sequencer.
// Depends on sfs_pkg for register indexes, widths and cfg_t.
module sfs_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [sfs_pkg::ADDR_W-1:0]  paddr,
	input  logic [sfs_pkg::DATA_W-1:0]  pwdata,
	output logic [sfs_pkg::DATA_W-1:0]  prdata,
	output sfs_pkg::cfg_t               cfg
);

	sfs_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr;

	assign idx = paddr[4:2];
	assign wr  = psel & penable & pwrite & pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_count    <= sfs_pkg::COUNT_W'(1);
			cfg_q.frame_duration <= sfs_pkg::DUR_W'(16667);
			cfg_q.speed          <= sfs_pkg::SPEED_W'(256);
			cfg_q.play_mode      <= sfs_pkg::MODE_ONCE;
			cfg_q.loop_total     <= sfs_pkg::LOOP_W'(1);
			cfg_q.event_start    <= '0;
			cfg_q.event_length   <= '0;
		end else if (wr) begin
			case (idx)
				sfs_pkg::REG_FRAME_COUNT:    cfg_q.frame_count    <= pwdata[8:0];
				sfs_pkg::REG_FRAME_DURATION: cfg_q.frame_duration <= pwdata[23:0];
				sfs_pkg::REG_SPEED:          cfg_q.speed          <= pwdata[15:0];
				sfs_pkg::REG_PLAY_MODE:      cfg_q.play_mode      <= pwdata[1:0];
				sfs_pkg::REG_LOOP_TOTAL:     cfg_q.loop_total     <= pwdata[15:0];
				sfs_pkg::REG_EVENT_START:    cfg_q.event_start    <= pwdata[7:0];
				sfs_pkg::REG_EVENT_LENGTH:   cfg_q.event_length   <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			sfs_pkg::REG_FRAME_COUNT:    prdata = {23'd0, cfg_q.frame_count};
			sfs_pkg::REG_FRAME_DURATION: prdata = {8'd0, cfg_q.frame_duration};
			sfs_pkg::REG_SPEED:          prdata = {16'd0, cfg_q.speed};
			sfs_pkg::REG_PLAY_MODE:      prdata = {30'd0, cfg_q.play_mode};
			sfs_pkg::REG_LOOP_TOTAL:     prdata = {16'd0, cfg_q.loop_total};
			sfs_pkg::REG_EVENT_START:    prdata = {24'd0, cfg_q.event_start};
			sfs_pkg::REG_EVENT_LENGTH:   prdata = {23'd0, cfg_q.event_length};
			default:                     prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/sfs_core.sv
// Sequencer state and its single-pass update for one registered request.
// Depends on sfs_pkg for cfg_t, item_t, res_t and the mode/op codes.
module sfs_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,   // item is consumed this cycle
	input  sfs_pkg::item_t item,
	input  sfs_pkg::cfg_t  cfg,
	output sfs_pkg::res_t  res
);

	logic [sfs_pkg::FRAME_W-1:0] cur_q, cur_n;
	logic [sfs_pkg::ACC_W-1:0]   acc_q, acc_n;
	logic [sfs_pkg::LOOP_W-1:0]  loops_q, loops_n;
	logic                        done_q, done_n;
	logic                        lev_valid_q, lev_valid_n;
	logic [sfs_pkg::FRAME_W-1:0] lev_frame_q, lev_frame_n;

	logic [sfs_pkg::COUNT_W-1:0] count, last, lo, hi;
	logic [sfs_pkg::COUNT_W:0]   hi_raw;
	logic [sfs_pkg::DUR_W-1:0]   dur;
	logic [sfs_pkg::ACC_W-1:0]   thr, acc_sat;
	logic [sfs_pkg::ACC_W:0]     sum;
	logic [sfs_pkg::FRAME_W-1:0] cur_c;
	logic [sfs_pkg::COUNT_W-1:0] inc;
	logic                        step, win_b, win_a, ev_b, ev_a, fin_now;

	// effective frame count, threshold and clamped event window
	always_comb begin
		if (cfg.frame_count == '0)
			count = sfs_pkg::COUNT_W'(1);
		else if (cfg.frame_count > sfs_pkg::COUNT_W'(sfs_pkg::MAX_FRAMES))
			count = sfs_pkg::COUNT_W'(sfs_pkg::MAX_FRAMES);
		else
			count = cfg.frame_count;
		last   = count - sfs_pkg::COUNT_W'(1);
		dur    = (cfg.frame_duration == '0) ? sfs_pkg::DUR_W'(1) : cfg.frame_duration;
		thr    = {dur, 8'd0};
		lo     = ({1'b0, cfg.event_start} > last) ? last : {1'b0, cfg.event_start};
		hi_raw = {1'b0, lo} + {1'b0, cfg.event_length} - (sfs_pkg::COUNT_W+1)'(1);
		hi     = (hi_raw > {1'b0, last}) ? last : hi_raw[sfs_pkg::COUNT_W-1:0];
	end

	always_comb begin
		cur_n       = cur_q;
		acc_n       = acc_q;
		loops_n     = loops_q;
		done_n      = done_q;
		lev_valid_n = lev_valid_q;
		lev_frame_n = lev_frame_q;
		ev_b        = 1'b0;
		ev_a        = 1'b0;
		fin_now     = 1'b0;
		cur_c       = ({1'b0, cur_q} >= count) ? last[sfs_pkg::FRAME_W-1:0] : cur_q;
		sum         = {1'b0, acc_q} + {1'b0, item.scaled};
		acc_sat     = sum[sfs_pkg::ACC_W] ? '1 : sum[sfs_pkg::ACC_W-1:0];
		step        = (acc_sat >= thr);
		inc         = {1'b0, cur_c} + sfs_pkg::COUNT_W'(1);
		win_b       = (cfg.event_length != '0) && ({1'b0, cur_c} >= lo) && ({1'b0, cur_c} <= hi);
		win_a       = 1'b0;

		if (item.op == sfs_pkg::OP_RESTART) begin
			cur_n       = '0;
			acc_n       = '0;
			done_n      = 1'b0;
			lev_valid_n = 1'b0;
			lev_frame_n = '0;
			if (cfg.play_mode == sfs_pkg::MODE_COUNTED && cfg.loop_total != '0)
				loops_n = cfg.loop_total;
			else
				loops_n = sfs_pkg::LOOP_W'(1);
		end else if (!done_q) begin
			cur_n = cur_c;
			ev_b  = win_b && !(lev_valid_q && lev_frame_q == cur_c);
			if (ev_b) begin
				lev_valid_n = 1'b1;
				lev_frame_n = cur_c;
			end
			acc_n = acc_sat;
			if (step) begin
				acc_n = acc_sat - thr;
				cur_n = inc[sfs_pkg::FRAME_W-1:0];
				if (inc >= count) begin
					if (cfg.play_mode == sfs_pkg::MODE_LOOP) begin
						cur_n = '0;
					end else if (cfg.play_mode == sfs_pkg::MODE_COUNTED &&
					             loops_q > sfs_pkg::LOOP_W'(1)) begin
						loops_n = loops_q - sfs_pkg::LOOP_W'(1);
						cur_n   = '0;
					end else begin
						if (cfg.play_mode == sfs_pkg::MODE_COUNTED)
							loops_n = '0;
						cur_n   = last[sfs_pkg::FRAME_W-1:0];
						done_n  = 1'b1;
						fin_now = 1'b1;
					end
				end
				win_a = (cfg.event_length != '0) && ({1'b0, cur_n} >= lo) &&
				        ({1'b0, cur_n} <= hi);
				// the frame just entered may equal the one marked above
				ev_a  = !done_n && win_a && !(lev_valid_n && lev_frame_n == cur_n);
				if (ev_a) begin
					lev_valid_n = 1'b1;
					lev_frame_n = cur_n;
				end
			end
		end

		res.frame_index  = cur_n;
		res.event_before = ev_b;
		res.event_after  = ev_a;
		res.finished_now = fin_now;
		res.finished     = done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			acc_q       <= '0;
			loops_q     <= sfs_pkg::LOOP_W'(1);
			done_q      <= 1'b0;
			lev_valid_q <= 1'b0;
			lev_frame_q <= '0;
		end else if (advance) begin
			cur_q       <= cur_n;
			acc_q       <= acc_n;
			loops_q     <= loops_n;
			done_q      <= done_n;
			lev_valid_q <= lev_valid_n;
			lev_frame_q <= lev_frame_n;
		end
	end

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.op == sfs_pkg::OP_RESTART |=> cur_q == '0 && acc_q == '0 && !done_q)
		else $error("restart did not clear sequencer state");

	a_frozen_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		advance && done_q && item.op == sfs_pkg::OP_TICK |=>
		$stable(cur_q) && $stable(acc_q) && $stable(loops_q) && done_q)
		else $error("finished animation changed on a tick");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cur_q) && $stable(acc_q) && $stable(done_q))
		else $error("state moved without a request");

	a_finish_fires_once: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.finished_now |-> !done_q && !res.event_after)
		else $error("finish flagged on an already finished animation");

endmodule

FILE: tb/sfs_result_checker.sv
// Result checker for the sprite frame sequencer: tracks register writes, predicts
// each result from the accepted requests and compares it with the block's output.
// Depends on sfs_pkg for widths, register indexes, play modes and result type.
module sfs_result_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        operation,
	input  logic [sfs_pkg::DELTA_W-1:0] delta_time,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [sfs_pkg::FRAME_W-1:0] frame_index,
	input  logic                        event_before,
	input  logic                        event_after,
	input  logic                        finished_now,
	input  logic                        finished,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfs_pkg::ADDR_W-1:0]  paddr,
	input  logic [sfs_pkg::DATA_W-1:0]  pwdata,
	input  logic                        pready,
	output int                          mismatches,
	output int                          outstanding
);

	localparam longint unsigned ACC_MAX = (64'd1 << sfs_pkg::ACC_W) - 64'd1;

	sfs_pkg::cfg_t    cfg;
	int unsigned      frame_pos;
	longint unsigned  acc_units;    // 1/256 us
	int unsigned      loops_left;
	bit               frozen;
	bit               event_seen;
	int unsigned      event_frame;
	sfs_pkg::res_t    expected_frames[$];

	function automatic void rearm_strip();
		frame_pos = 0;
		acc_units = 0;
		frozen = 1'b0;
		event_seen = 1'b0;
		event_frame = 0;
		if (cfg.play_mode == sfs_pkg::MODE_COUNTED) begin
			loops_left = (cfg.loop_total == '0) ? 1 : 32'(cfg.loop_total);
		end else begin
			loops_left = 1;
		end
	endfunction

	// fires for a frame of the clamped window unless it was the last frame fired for
	function automatic bit window_event(int unsigned count);
		int unsigned lo;
		int unsigned hi;
		if (cfg.event_length == '0)
			return 1'b0;
		lo = 32'(cfg.event_start);
		if (lo > count - 1)
			lo = count - 1;
		hi = lo + 32'(cfg.event_length) - 1;
		if (hi > count - 1)
			hi = count - 1;
		if (frame_pos < lo || frame_pos > hi)
			return 1'b0;
		if (event_seen && event_frame == frame_pos)
			return 1'b0;
		event_seen = 1'b1;
		event_frame = frame_pos;
		return 1'b1;
	endfunction

	function automatic sfs_pkg::res_t step_animation(logic op, logic [sfs_pkg::DELTA_W-1:0] dt);
		sfs_pkg::res_t   r;
		int unsigned     count;
		longint unsigned threshold;
		longint unsigned scaled;
		r = '0;
		if (op == sfs_pkg::OP_RESTART) begin
			rearm_strip();
		end else if (!frozen) begin
			count = 32'(cfg.frame_count);
			if (count == 0)
				count = 1;
			if (count > sfs_pkg::MAX_FRAMES)
				count = sfs_pkg::MAX_FRAMES;
			threshold = 64'(cfg.frame_duration);
			if (threshold == 0)
				threshold = 1;
			threshold = threshold << 8;
			scaled = 64'(dt);
			scaled = scaled * 64'(cfg.speed);
			// frame count may have been lowered under a running strip
			if (frame_pos >= count)
				frame_pos = count - 1;
			r.event_before = window_event(count);
			if (scaled > ACC_MAX - acc_units)
				acc_units = ACC_MAX;
			else
				acc_units = acc_units + scaled;
			if (acc_units >= threshold) begin
				acc_units = acc_units - threshold;
				frame_pos++;
				if (frame_pos >= count) begin
					if (cfg.play_mode == sfs_pkg::MODE_LOOP) begin
						frame_pos = 0;
					end else if (cfg.play_mode == sfs_pkg::MODE_COUNTED && loops_left > 1) begin
						loops_left--;
						frame_pos = 0;
					end else begin
						if (cfg.play_mode == sfs_pkg::MODE_COUNTED)
							loops_left = 0;
						frame_pos = count - 1;
						frozen = 1'b1;
						r.finished_now = 1'b1;
					end
				end
				if (!frozen)
					r.event_after = window_event(count);
			end
		end
		r.frame_index = frame_pos[sfs_pkg::FRAME_W-1:0];
		r.finished = frozen;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sfs_pkg::res_t want;
		if (!arst_n) begin
			cfg.frame_count = sfs_pkg::COUNT_W'(1);
			cfg.frame_duration = sfs_pkg::DUR_W'(16667);
			cfg.speed = sfs_pkg::SPEED_W'(256);
			cfg.play_mode = sfs_pkg::MODE_ONCE;
			cfg.loop_total = sfs_pkg::LOOP_W'(1);
			cfg.event_start = '0;
			cfg.event_length = '0;
			rearm_strip();
			expected_frames.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[sfs_pkg::ADDR_W-1:2])
					sfs_pkg::REG_FRAME_COUNT:    cfg.frame_count = pwdata[sfs_pkg::COUNT_W-1:0];
					sfs_pkg::REG_FRAME_DURATION: cfg.frame_duration = pwdata[sfs_pkg::DUR_W-1:0];
					sfs_pkg::REG_SPEED:          cfg.speed = pwdata[sfs_pkg::SPEED_W-1:0];
					sfs_pkg::REG_PLAY_MODE:      cfg.play_mode = pwdata[1:0];
					sfs_pkg::REG_LOOP_TOTAL:     cfg.loop_total = pwdata[sfs_pkg::LOOP_W-1:0];
					sfs_pkg::REG_EVENT_START:    cfg.event_start = pwdata[sfs_pkg::FRAME_W-1:0];
					sfs_pkg::REG_EVENT_LENGTH:   cfg.event_length = pwdata[sfs_pkg::COUNT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_frames.size() == 0) begin
					$error("unexpected result: frame_index %0d", frame_index);
					mismatches++;
				end else begin
					want = expected_frames.pop_front();
					check_field("frame_index", 32'(want.frame_index), 32'(frame_index));
					check_field("event_before", 32'(want.event_before), 32'(event_before));
					check_field("event_after", 32'(want.event_after), 32'(event_after));
					check_field("finished_now", 32'(want.finished_now), 32'(finished_now));
					check_field("finished", 32'(want.finished), 32'(finished));
				end
			end
			if (in_valid && in_ready)
				expected_frames.insert(expected_frames.size(),
					step_animation(operation, delta_time));
			outstanding = expected_frames.size();
		end
	end

endmodule

FILE: tb/tb_sprite_frame_sequencer_unit.sv
// Testbench top for sprite_frame_sequencer_unit: drives requests, results and APB.
// Depends on sfs_pkg, the block and sfs_result_checker, which does all checking.
module tb_sprite_frame_sequencer_unit;

	// play mode code the block treats as play once
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic                        operation;
	logic [sfs_pkg::DELTA_W-1:0] delta_time;
	logic                        out_valid;
	logic                        out_ready;
	logic [sfs_pkg::FRAME_W-1:0] frame_index;
	logic                        event_before;
	logic                        event_after;
	logic                        finished_now;
	logic                        finished;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [sfs_pkg::ADDR_W-1:0]  paddr;
	logic [sfs_pkg::DATA_W-1:0]  pwdata;
	logic [sfs_pkg::DATA_W-1:0]  prdata;
	logic                        pready;

	int mismatches;
	int outstanding;

	bit steady;          // current phase runs without gaps or stalls
	bit seen_finished;   // latest accepted result reported a frozen strip

	// last value written to each register, indexed by register code
	logic [31:0] setting [7];

	sprite_frame_sequencer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.delta_time   (delta_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_index  (frame_index),
		.event_before (event_before),
		.event_after  (event_after),
		.finished_now (finished_now),
		.finished     (finished),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	sfs_result_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.delta_time   (delta_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_index  (frame_index),
		.event_before (event_before),
		.event_after  (event_after),
		.finished_now (finished_now),
		.finished     (finished),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop; a correct run ends well before it.
	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

	// APB write: setup, access until pready, then idle with psel low, so that psel
	// never gets two assignments in the same step across back-to-back writes.
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Write the registers picked by the mask from the setting array.
	task automatic commit_setting(logic [6:0] which);
		if (which[sfs_pkg::REG_FRAME_COUNT])
			write_reg(sfs_pkg::REG_FRAME_COUNT, setting[sfs_pkg::REG_FRAME_COUNT]);
		if (which[sfs_pkg::REG_FRAME_DURATION])
			write_reg(sfs_pkg::REG_FRAME_DURATION, setting[sfs_pkg::REG_FRAME_DURATION]);
		if (which[sfs_pkg::REG_SPEED])
			write_reg(sfs_pkg::REG_SPEED, setting[sfs_pkg::REG_SPEED]);
		if (which[sfs_pkg::REG_PLAY_MODE])
			write_reg(sfs_pkg::REG_PLAY_MODE, setting[sfs_pkg::REG_PLAY_MODE]);
		if (which[sfs_pkg::REG_LOOP_TOTAL])
			write_reg(sfs_pkg::REG_LOOP_TOTAL, setting[sfs_pkg::REG_LOOP_TOTAL]);
		if (which[sfs_pkg::REG_EVENT_START])
			write_reg(sfs_pkg::REG_EVENT_START, setting[sfs_pkg::REG_EVENT_START]);
		if (which[sfs_pkg::REG_EVENT_LENGTH])
			write_reg(sfs_pkg::REG_EVENT_LENGTH, setting[sfs_pkg::REG_EVENT_LENGTH]);
	endtask

	task automatic program_all(int unsigned cnt, int unsigned dur, int unsigned spd,
			logic [1:0] mode, int unsigned loops, int unsigned evs, int unsigned evl);
		setting[sfs_pkg::REG_FRAME_COUNT] = cnt;
		setting[sfs_pkg::REG_FRAME_DURATION] = dur;
		setting[sfs_pkg::REG_SPEED] = spd;
		setting[sfs_pkg::REG_PLAY_MODE] = 32'(mode);
		setting[sfs_pkg::REG_LOOP_TOTAL] = loops;
		setting[sfs_pkg::REG_EVENT_START] = evs;
		setting[sfs_pkg::REG_EVENT_LENGTH] = evl;
		commit_setting('1);
	endtask

	// Random subset of registers with values biased toward the edges:
	// zero and oversized frame counts, zero and full durations, zero speed,
	// the unused play mode, zero loop totals and windows past the strip.
	task automatic random_setting();
		logic [6:0] which;
		which = 7'($urandom);
		if (which[sfs_pkg::REG_FRAME_COUNT]) begin
			case ($urandom_range(0, 6))
				0: setting[sfs_pkg::REG_FRAME_COUNT] = 1;
				1: setting[sfs_pkg::REG_FRAME_COUNT] = 2;
				2: setting[sfs_pkg::REG_FRAME_COUNT] = $urandom_range(3, 8);
				3: setting[sfs_pkg::REG_FRAME_COUNT] = $urandom_range(9, 40);
				4: setting[sfs_pkg::REG_FRAME_COUNT] = sfs_pkg::MAX_FRAMES;
				5: setting[sfs_pkg::REG_FRAME_COUNT] = 0;
				default: setting[sfs_pkg::REG_FRAME_COUNT] = $urandom_range(257, 511);
			endcase
		end
		if (which[sfs_pkg::REG_FRAME_DURATION]) begin
			case ($urandom_range(0, 5))
				0: setting[sfs_pkg::REG_FRAME_DURATION] = 0;
				1: setting[sfs_pkg::REG_FRAME_DURATION] = 1;
				2: setting[sfs_pkg::REG_FRAME_DURATION] = $urandom_range(2, 64);
				3: setting[sfs_pkg::REG_FRAME_DURATION] = $urandom_range(65, 4000);
				4: setting[sfs_pkg::REG_FRAME_DURATION] = 32'hFFFFFF;
				default: setting[sfs_pkg::REG_FRAME_DURATION] = $urandom & 32'hFFFFFF;
			endcase
		end
		if (which[sfs_pkg::REG_SPEED]) begin
			case ($urandom_range(0, 4))
				0: setting[sfs_pkg::REG_SPEED] = 0;
				1: setting[sfs_pkg::REG_SPEED] = 256;
				2: setting[sfs_pkg::REG_SPEED] = 32'hFFFF;
				3: setting[sfs_pkg::REG_SPEED] = $urandom_range(1, 1023);
				default: setting[sfs_pkg::REG_SPEED] = $urandom & 32'hFFFF;
			endcase
		end
		if (which[sfs_pkg::REG_PLAY_MODE])
			setting[sfs_pkg::REG_PLAY_MODE] = $urandom_range(0, 3);
		if (which[sfs_pkg::REG_LOOP_TOTAL]) begin
			case ($urandom_range(0, 4))
				0: setting[sfs_pkg::REG_LOOP_TOTAL] = 0;
				1: setting[sfs_pkg::REG_LOOP_TOTAL] = 1;
				2: setting[sfs_pkg::REG_LOOP_TOTAL] = $urandom_range(2, 5);
				3: setting[sfs_pkg::REG_LOOP_TOTAL] = 32'hFFFF;
				default: setting[sfs_pkg::REG_LOOP_TOTAL] = $urandom & 32'hFFFF;
			endcase
		end
		if (which[sfs_pkg::REG_EVENT_START]) begin
			if ($urandom_range(0, 1) == 0)
				setting[sfs_pkg::REG_EVENT_START] = $urandom_range(0, 8);
			else
				setting[sfs_pkg::REG_EVENT_START] = $urandom_range(0, 255);
		end
		if (which[sfs_pkg::REG_EVENT_LENGTH]) begin
			case ($urandom_range(0, 3))
				0: setting[sfs_pkg::REG_EVENT_LENGTH] = 0;
				1: setting[sfs_pkg::REG_EVENT_LENGTH] = $urandom_range(1, 8);
				2: setting[sfs_pkg::REG_EVENT_LENGTH] = sfs_pkg::MAX_FRAMES;
				default: setting[sfs_pkg::REG_EVENT_LENGTH] = $urandom_range(0, 511);
			endcase
		end
		commit_setting(which);
	endtask

	// One request on the input channel. Gap first (valid low), then hold
	// valid and payload until the edge that sees ready.
	task automatic send_request(logic op, logic [sfs_pkg::DELTA_W-1:0] dt);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		delta_time <= dt;
		do @(posedge clk); while (!in_ready);
	endtask

	// Random request. Some deltas are scaled to the current frame length so
	// that frames advance at varied rates; a frozen strip is restarted often
	// so that ticks keep reaching the sequencing logic.
	task automatic random_request();
		logic                        op;
		logic [sfs_pkg::DELTA_W-1:0] dt;
		int unsigned                 dur;
		int unsigned                 spd;
		int unsigned                 typical;
		bit                          restart;
		dur = 32'(setting[sfs_pkg::REG_FRAME_DURATION][sfs_pkg::DUR_W-1:0]);
		spd = 32'(setting[sfs_pkg::REG_SPEED][sfs_pkg::SPEED_W-1:0]);
		if (seen_finished)
			restart = ($urandom_range(0, 1) == 0);
		else
			restart = ($urandom_range(0, 24) == 0);
		op = restart ? sfs_pkg::OP_RESTART : sfs_pkg::OP_TICK;
		case ($urandom_range(0, 3))
			0: dt = sfs_pkg::DELTA_W'($urandom_range(0, 3));
			1: dt = sfs_pkg::DELTA_W'($urandom_range(0, 255));
			2: begin
				typical = (spd == 0) ? 32767 : (dur * 256) / spd;
				if (typical > 32767)
					typical = 32767;
				dt = sfs_pkg::DELTA_W'($urandom_range(0, 2 * typical + 1));
			end
			default: dt = sfs_pkg::DELTA_W'($urandom);
		endcase
		send_request(op, dt);
	endtask

	// Let every outstanding result drain and idle the two-stage pipe before
	// anything touches the registers.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result side: random stall before each result, none in steady phases.
	initial begin : result_sink
		int unsigned stall;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			seen_finished = finished;
		end
	end

	initial begin : stimulus
		int unsigned sent_items;
		int unsigned phase_items;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = sfs_pkg::OP_TICK;
		delta_time = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		steady = 1'b0;
		seen_finished = 1'b0;
		sent_items = 0;
		// mirror of the reset values
		setting[sfs_pkg::REG_FRAME_COUNT] = 1;
		setting[sfs_pkg::REG_FRAME_DURATION] = 16667;
		setting[sfs_pkg::REG_SPEED] = 256;
		setting[sfs_pkg::REG_PLAY_MODE] = 32'(sfs_pkg::MODE_ONCE);
		setting[sfs_pkg::REG_LOOP_TOTAL] = 1;
		setting[sfs_pkg::REG_EVENT_START] = 0;
		setting[sfs_pkg::REG_EVENT_LENGTH] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, one frame, play once: no advance, then exactly reach
		// the threshold and finish, a tick while frozen, restart with a delta.
		send_request(sfs_pkg::OP_TICK, 16'd0);
		send_request(sfs_pkg::OP_TICK, 16'd16666);
		send_request(sfs_pkg::OP_TICK, 16'd1);
		send_request(sfs_pkg::OP_TICK, 16'hFFFF);
		send_request(sfs_pkg::OP_RESTART, 16'hFFFF);
		settle();

		// Counted, two passes over four frames, event window on frames 1..2;
		// one frame per tick, ends frozen on frame 3.
		program_all(4, 1, 256, sfs_pkg::MODE_COUNTED, 2, 1, 2);
		send_request(sfs_pkg::OP_RESTART, 16'd0);
		repeat (9) send_request(sfs_pkg::OP_TICK, 16'd1);
		settle();

		// Zero count and zero loop total, full duration, full speed, unused
		// mode, window clamped past the end: the accumulator saturates.
		program_all(0, 32'hFFFFFF, 32'hFFFF, MODE_UNUSED, 0, 255, 511);
		send_request(sfs_pkg::OP_RESTART, 16'd0);
		send_request(sfs_pkg::OP_TICK, 16'hFFFF);
		send_request(sfs_pkg::OP_TICK, 16'hFFFF);
		settle();

		// Looping strip of eight, then the count drops under the current
		// frame without a restart.
		program_all(8, 2, 32'hFFFF, sfs_pkg::MODE_LOOP, 1, 0, 256);
		send_request(sfs_pkg::OP_RESTART, 16'd0);
		repeat (5) send_request(sfs_pkg::OP_TICK, 16'd1);
		settle();
		setting[sfs_pkg::REG_FRAME_COUNT] = 3;
		commit_setting(7'd1 << sfs_pkg::REG_FRAME_COUNT);
		send_request(sfs_pkg::OP_TICK, 16'd0);
		settle();

		// Random phases: new register values between phases, a restart at the
		// start of most phases, then a burst of requests.
		while (sent_items < 1500) begin
			random_setting();
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) != 0) begin
				send_request(sfs_pkg::OP_RESTART, sfs_pkg::DELTA_W'($urandom));
				sent_items++;
			end
			phase_items = $urandom_range(20, 80);
			repeat (phase_items) begin
				sent_items++;
				random_request();
			end
			settle();
		end

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sprite_frame_sequencer_unit.f
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_regs.sv
hw/rtl/sfs_core.sv
hw/rtl/sprite_frame_sequencer_unit.sv
tb/sfs_result_checker.sv
tb/tb_sprite_frame_sequencer_unit.sv
